/* design/double_ended_queue_macros.svh */
// Assertion macros for the double-ended queue.
// Included by files that carry concurrent assertions; depends on nothing else.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* design/deq_pkg.sv */
// Shared types and constants for the double-ended queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package deq_pkg;

  localparam int OCC_W = 5;

  localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [1:0] MODE_PUSH_BACK  = 2'd1;
  localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [1:0] MODE_POP_BACK   = 2'd3;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic load_out;
  } cmd_t;

endpackage

`default_nettype wire

/* design/deq_ctrl.sv */
// Controller of the double-ended queue: request sequencing and response valid.
// Depends on deq_pkg for the command struct.
`default_nettype none

module deq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output deq_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  assign req_ready    = (state == ST_IDLE);
  assign rsp_valid    = out_valid;
  assign cmd.accept   = req_valid && req_ready;
  assign cmd.load_out = (state == ST_EXEC) && (!out_valid || rsp_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

/* design/deq_datapath.sv */
// Datapath of the double-ended queue: ring store, front pointer, count, response register.
// Depends on deq_pkg for payload and command types and the mode and status codes.
`default_nettype none

module deq_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  deq_pkg::cmd_t cmd,
  input  deq_pkg::req_t req,
  output deq_pkg::rsp_t rsp
);

  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = (CNT_W > deq_pkg::OCC_W) ? CNT_W : deq_pkg::OCC_W;
  localparam logic [CNT_W:0]   CAP_S   = (CNT_W + 1)'(CAPACITY);
  localparam logic [PTR_W-1:0] LAST_IX = PTR_W'(CAPACITY - 1);

  logic [31:0]      mem [CAPACITY];
  logic [PTR_W-1:0] front;
  logic [PTR_W-1:0] front_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [31:0]      rd_data;
  logic [1:0]       pend_status;
  logic             pend_pop;

  logic             full;
  logic             empty;
  logic [PTR_W-1:0] front_inc;
  logic [PTR_W-1:0] front_dec;
  logic [CNT_W:0]   back_sum;
  logic [CNT_W:0]   last_sum;
  logic [PTR_W-1:0] back_wr;
  logic [PTR_W-1:0] back_rd;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic [1:0]       status;
  logic [EXT_W-1:0] count_ext;

  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign front_inc = (front == LAST_IX) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? LAST_IX : front - 1'b1;
  assign back_sum  = {1'b0, count} + (CNT_W + 1)'(front);
  assign last_sum  = back_sum - 1'b1;
  assign back_wr   = PTR_W'((back_sum >= CAP_S) ? back_sum - CAP_S : back_sum);
  assign back_rd   = PTR_W'((last_sum >= CAP_S) ? last_sum - CAP_S : last_sum);
  assign count_ext = EXT_W'(count);

  always_comb begin
    front_next = front;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = back_wr;
    rd_en      = 1'b0;
    rd_addr    = front;
    status     = deq_pkg::STAT_DONE;
    case (req.mode)
      deq_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          status = deq_pkg::STAT_FULL;
        end else begin
          front_next = front_dec;
          count_next = count + 1'b1;
          wr_en      = 1'b1;
          wr_addr    = front_dec;
        end
      end
      deq_pkg::MODE_PUSH_BACK: begin
        if (full) begin
          status = deq_pkg::STAT_FULL;
        end else begin
          count_next = count + 1'b1;
          wr_en      = 1'b1;
        end
      end
      deq_pkg::MODE_POP_FRONT: begin
        if (empty) begin
          status = deq_pkg::STAT_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - 1'b1;
          rd_en      = 1'b1;
        end
      end
      default: begin
        if (empty) begin
          status = deq_pkg::STAT_EMPTY;
        end else begin
          count_next = count - 1'b1;
          rd_en      = 1'b1;
          rd_addr    = back_rd;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[wr_addr] <= req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_status <= status;
      pend_pop    <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.status        <= pend_status;
      rsp.removed_value <= pend_pop ? rd_data : '0;
      rsp.occupancy     <= count_ext[deq_pkg::OCC_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* design/double_ended_queue.sv */
// Bounded double-ended queue of signed 32-bit values held in a ring store.
// Usage:
//   Requests arrive on req (mode, value) under req_valid/req_ready; each one
//   pushes at the front or back, or pops from the front or back.
//   Every transaction on req yields exactly one transaction on rsp (status,
//   removed_value, occupancy) under rsp_valid/rsp_ready, in request order.
//   A pop on an empty queue and a push on a full queue leave the contents
//   unchanged and are reported in status; removed_value is zero then.
//   After a request is accepted, the controller moves to its execute state and
//   from there loads the response register and raises rsp_valid. No new request
//   is accepted before the last one is in the response register: popped data
//   passes the synchronous read register of the ring store on its way there.
//   A response waiting on rsp does not block the next request from being
//   accepted; that request then holds until the response register frees up.
//   While rsp_ready is low nothing is lost: the response is held steady.
//   Synchronous reset empties the queue and drops any pending response;
//   store contents are not cleared and are only read after being written.
// Depends on deq_pkg, deq_ctrl, deq_datapath and the assertion macro header.
`default_nettype none

`include "double_ended_queue_macros.svh"

module double_ended_queue #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  deq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output deq_pkg::rsp_t rsp
);

  deq_pkg::cmd_t cmd;
  logic          rsp_drained;
  logic          rsp_refused;
  logic          rsp_has_value;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  deq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

  assign rsp_drained   = rsp_valid && rsp_ready && !cmd.load_out;
  assign rsp_refused   = rsp_valid && (rsp.status != deq_pkg::STAT_DONE);
  assign rsp_has_value = (rsp.removed_value != '0);

  `DEQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd.accept, !req_ready, "accepted while busy")
  `DEQ_ASSERT_NEXT(a_load_gives_valid, clk, rst, cmd.load_out, rsp_valid, "response not shown")
  `DEQ_ASSERT_NEXT(a_taken_clears, clk, rst, rsp_drained, !rsp_valid, "response repeated")
  `DEQ_ASSERT_SAME(a_fail_no_value, clk, rst, rsp_refused, !rsp_has_value, "refusal with a value")

endmodule

`default_nettype wire
